// ===== sv/cvb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and register codes for the cell voltage balance decider.
package cvb_pkg;

    localparam int CELLS         = 6;
    localparam int HISTORY_DEPTH = 8;

    localparam int MV_W      = 13;
    localparam int CELL_W    = 3;
    localparam int SLOT_W    = 3;
    localparam int RAW_W     = 16;
    localparam int ADC_W     = 14;
    localparam int MASK_W    = 8;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = ADC_W + MV_W;

    localparam logic [ADC_W-1:0] ADC_MAX       = 14'd16383;
    localparam logic [MV_W-1:0]  FULL_SCALE_MV = 13'd6250;

    // running sum of one cell's history
    localparam int SUM_W     = $clog2(6250 * HISTORY_DEPTH + 1);
    localparam int CIDX_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int MEM_DEPTH = CELLS * HISTORY_DEPTH;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // command queue and result queue
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CELL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FORCED_EN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORCED_MV = 3'd4;

    localparam logic [MV_W-1:0] RST_MAX_CELL  = 13'd4200;
    localparam logic [MV_W-1:0] RST_GAP       = 13'd50;
    localparam logic [MV_W-1:0] RST_START     = 13'd3400;
    localparam logic            RST_FORCED_EN = 1'b0;
    localparam logic [MV_W-1:0] RST_FORCED_MV = 13'd0;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_SKIP,
        KIND_BALANCE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CELL_W-1:0] cell_id;
        logic [SLOT_W-1:0] slot;
        logic [MV_W-1:0]   mv;
        logic [MV_W-1:0]   min_ref;
    } t_cmd;

    typedef struct packed {
        logic [MV_W-1:0]   average_mv;
        logic              average_changed;
        logic [MV_W-1:0]   scan_min_mv;
        logic [CELL_W-1:0] scan_min_cell;
        logic [MV_W-1:0]   scan_max_mv;
        logic [CELL_W-1:0] scan_max_cell;
        logic [MASK_W-1:0] balance_mask;
        logic [CNT_W-1:0]  balance_count;
    } t_res;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [MV_W-1:0]      data;
    } t_cfg_wr;

endpackage

// ===== sv/cvb_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats, classifies them and converts raw readings to mV.
module cvb_front import cvb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_command,
    input  logic [CELL_W-1:0] i_cell_index,
    input  logic [RAW_W-1:0]  i_raw_adc,
    input  logic [SLOT_W-1:0] i_history_slot,
    input  logic [MV_W-1:0]   i_min_reference_mv,
    output logic              o_cq_push,
    output t_cmd              o_cmd,
    input  logic              i_cq_full
);

    logic              r_vld;
    t_kind             r_kind;
    logic [CELL_W-1:0] r_cell;
    logic [SLOT_W-1:0] r_slot;
    logic [PROD_W-1:0] r_prod;
    logic [MV_W-1:0]   r_min_ref;

    logic              in_acc;
    logic [ADC_W-1:0]  sat;
    t_kind             kind;
    logic [MV_W-1:0]   q_hi;
    logic [ADC_W:0]    rem;

    assign o_full    = r_vld && i_cq_full;
    assign in_acc    = i_push && !o_full;
    assign o_cq_push = r_vld && !i_cq_full;

    always_comb begin
        sat = (i_raw_adc > RAW_W'(ADC_MAX)) ? ADC_MAX : i_raw_adc[ADC_W-1:0];
        if (i_command) begin
            kind = KIND_BALANCE;
        end else if (({1'b0, i_cell_index} < (CELL_W+1)'(CELLS)) &&
                     ({1'b0, i_history_slot} < (SLOT_W+1)'(HISTORY_DEPTH))) begin
            kind = KIND_SAMPLE;
        end else begin
            kind = KIND_SKIP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (in_acc) begin
            r_vld <= 1'b1;
        end else if (o_cq_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind    <= kind;
            r_cell    <= i_cell_index;
            r_slot    <= i_history_slot;
            r_prod    <= PROD_W'(sat) * PROD_W'(FULL_SCALE_MV);
            r_min_ref <= i_min_reference_mv;
        end
    end

    // divide by 2^14-1: p = q*2^14 + lo gives p - q*16383 = lo + q, below 2*16383
    always_comb begin
        q_hi = r_prod[PROD_W-1:ADC_W];
        rem  = (ADC_W+1)'(r_prod[ADC_W-1:0]) + (ADC_W+1)'(q_hi);
        o_cmd.kind    = r_kind;
        o_cmd.cell_id = r_cell;
        o_cmd.slot    = r_slot;
        o_cmd.mv      = q_hi + MV_W'(rem >= (ADC_W+1)'(ADC_MAX));
        o_cmd.min_ref = r_min_ref;
    end

endmodule

// ===== sv/cvb_cmd_q.sv =====
`timescale 1ns / 1ps
// Command queue between the front end and the back end.
module cvb_cmd_q import cvb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr_ptr;
    logic [CQ_AW-1:0] r_rd_ptr;
    logic [CQ_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == CQ_AW'(CQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == CQ_AW'(CQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/cvb_back.sv =====
`timescale 1ns / 1ps
// Back end: history memory, running sums, scan min/max and balance decision.
module cvb_back import cvb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg_wr          i_cfg,
    input  logic             i_cq_empty,
    input  t_cmd             i_cmd,
    output logic             o_cq_pop,
    input  logic [RQ_CW-1:0] i_rq_count,
    output logic             o_rq_push,
    output t_res             o_res
);

    // configuration
    logic [MV_W-1:0] r_max_cell_mv;
    logic [MV_W-1:0] r_gap_mv;
    logic [MV_W-1:0] r_start_mv;
    logic            r_forced_en;
    logic [MV_W-1:0] r_forced_mv;

    // history store
    logic [MV_W-1:0]      r_hist [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_hist_vld;
    logic [MV_W-1:0]      r_rd_data;

    // execute stage
    logic              r_s1_vld;
    t_cmd              r_s1_cmd;
    logic [MEM_AW-1:0] r_s1_addr;

    // per-cell and scan state
    logic [SUM_W-1:0]  r_sum [CELLS];
    logic [MV_W-1:0]   r_avg [CELLS];
    logic [MV_W-1:0]   r_min_mv;
    logic [CELL_W-1:0] r_min_cell;
    logic [MV_W-1:0]   r_max_mv;
    logic [CELL_W-1:0] r_max_cell;
    logic [MASK_W-1:0] r_mask;
    logic [CNT_W-1:0]  r_cnt;

    logic [MV_W-1:0]   n_min_mv;
    logic [CELL_W-1:0] n_min_cell;
    logic [MV_W-1:0]   n_max_mv;
    logic [CELL_W-1:0] n_max_cell;
    logic [MASK_W-1:0] n_mask;
    logic [CNT_W-1:0]  n_cnt;

    logic              issue;
    logic [MEM_AW-1:0] rd_addr;
    logic              wr_en;
    logic              is_sample;
    logic              is_bal;
    logic [CIDX_W-1:0] cidx;
    logic [SUM_W-1:0]  sum_new;
    logic [MV_W-1:0]   avg_new;
    logic [MV_W-1:0]   ref_mv;
    logic [MV_W:0]     thr_mv;
    logic [MASK_W-1:0] bal_mask;
    logic [CNT_W-1:0]  bal_cnt;

    function automatic logic [MEM_AW-1:0] hist_addr(input logic [CELL_W-1:0] cell_id,
                                                    input logic [SLOT_W-1:0] slot);
        hist_addr = MEM_AW'(int'(cell_id) * HISTORY_DEPTH + int'(slot));
    endfunction

    // reserve a result slot for the beat in flight
    assign issue    = !i_cq_empty &&
                      ((RQ_CW+1)'(i_rq_count) + (RQ_CW+1)'(r_s1_vld) < (RQ_CW+1)'(RQ_DEPTH));
    assign o_cq_pop = issue;
    assign rd_addr  = (i_cmd.kind == KIND_SAMPLE) ? hist_addr(i_cmd.cell_id, i_cmd.slot) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cell_mv <= RST_MAX_CELL;
            r_gap_mv      <= RST_GAP;
            r_start_mv    <= RST_START;
            r_forced_en   <= RST_FORCED_EN;
            r_forced_mv   <= RST_FORCED_MV;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MAX_CELL:  r_max_cell_mv <= i_cfg.data;
                REG_GAP:       r_gap_mv      <= i_cfg.data;
                REG_START:     r_start_mv    <= i_cfg.data;
                REG_FORCED_EN: r_forced_en   <= i_cfg.data[0];
                REG_FORCED_MV: r_forced_mv   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_cmd  <= i_cmd;
            r_s1_addr <= rd_addr;
        end
    end

    // history memory: registered read, write from the execute stage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[r_s1_addr] <= r_s1_cmd.mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            if (wr_en && (r_s1_addr == rd_addr)) begin
                r_rd_data <= r_s1_cmd.mv;
            end else if (r_hist_vld[rd_addr]) begin
                r_rd_data <= r_hist[rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (wr_en) begin
            r_hist_vld[r_s1_addr] <= 1'b1;
        end
    end

    always_comb begin
        is_sample = r_s1_vld && (r_s1_cmd.kind == KIND_SAMPLE);
        is_bal    = r_s1_vld && (r_s1_cmd.kind == KIND_BALANCE);
        wr_en     = is_sample;
        cidx      = r_s1_cmd.cell_id[CIDX_W-1:0];
        sum_new   = r_sum[cidx] - SUM_W'(r_rd_data) + SUM_W'(r_s1_cmd.mv);
        avg_new   = MV_W'(sum_new / HISTORY_DEPTH);

        ref_mv = r_forced_en ? r_forced_mv : r_s1_cmd.min_ref;
        thr_mv = (MV_W+1)'(ref_mv) + (MV_W+1)'(r_gap_mv);
        bal_mask = '0;
        for (int c = 0; c < CELLS; c++) begin
            bal_mask[c] = (r_avg[c] > r_max_cell_mv) ||
                          (((MV_W+1)'(r_avg[c]) > thr_mv) && (r_avg[c] > r_start_mv));
        end
        bal_cnt = '0;
        for (int b = 0; b < MASK_W; b++) begin
            bal_cnt = bal_cnt + CNT_W'(bal_mask[b]);
        end

        n_min_mv   = r_min_mv;
        n_min_cell = r_min_cell;
        n_max_mv   = r_max_mv;
        n_max_cell = r_max_cell;
        n_mask     = r_mask;
        n_cnt      = r_cnt;
        if (is_sample) begin
            // cell 0 opens a new scan
            if ((r_s1_cmd.cell_id == '0) || (r_min_mv > avg_new)) begin
                n_min_mv   = avg_new;
                n_min_cell = r_s1_cmd.cell_id;
            end
            if ((r_s1_cmd.cell_id == '0) || (r_max_mv < avg_new)) begin
                n_max_mv   = avg_new;
                n_max_cell = r_s1_cmd.cell_id;
            end
        end
        if (is_bal) begin
            n_mask = bal_mask;
            n_cnt  = bal_cnt;
        end

        o_res.average_mv      = is_sample ? avg_new : '0;
        o_res.average_changed = is_sample && (avg_new != r_avg[cidx]);
        o_res.scan_min_mv     = n_min_mv;
        o_res.scan_min_cell   = n_min_cell;
        o_res.scan_max_mv     = n_max_mv;
        o_res.scan_max_cell   = n_max_cell;
        o_res.balance_mask    = n_mask;
        o_res.balance_count   = n_cnt;
    end

    assign o_rq_push = r_s1_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CELLS; c++) begin
                r_sum[c] <= '0;
                r_avg[c] <= '0;
            end
            r_min_mv   <= '0;
            r_min_cell <= '0;
            r_max_mv   <= '0;
            r_max_cell <= '0;
            r_mask     <= '0;
            r_cnt      <= '0;
        end else begin
            if (is_sample) begin
                r_sum[cidx] <= sum_new;
                r_avg[cidx] <= avg_new;
            end
            r_min_mv   <= n_min_mv;
            r_min_cell <= n_min_cell;
            r_max_mv   <= n_max_mv;
            r_max_cell <= n_max_cell;
            r_mask     <= n_mask;
            r_cnt      <= n_cnt;
        end
    end

endmodule

// ===== sv/cvb_res_q.sv =====
`timescale 1ns / 1ps
// Result queue feeding the output port.
module cvb_res_q import cvb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_res             i_res,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [RQ_CW-1:0] o_count,
    output t_res             o_res
);

    t_res             r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr_ptr;
    logic [RQ_AW-1:0] r_rd_ptr;
    logic [RQ_CW-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_res   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == RQ_AW'(RQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == RQ_AW'(RQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

// ===== sv/cell_voltage_balance_decider.sv =====
`timescale 1ns / 1ps
// Top level of the cell voltage balance decider.
//
// Input channel (push/full): one beat per command. A sample beat carries a cell
// index, history slot and raw 16-bit converter reading (saturated at 16383); it
// is converted to mV, written into that cell's history and the cell mean comes
// back. A balance beat compares every cell mean with the limits and returns the
// switch mask and its popcount. Every input beat yields exactly one result beat.
// Result channel (empty/pop): oldest result is on the o_ ports while empty is low.
// Config channel (valid/ready): ready is always high; write only while idle.
// A beat passes the front register, command queue, execute stage and result queue.
// Throughput: one beat per cycle unless stalled by full; the history memory has one
// read and one write port and a same-address write is forwarded to the next read.
// The back end issues only when the result queue has room for every beat in
// flight, so a stalled receiver fills the result queue, then the command queue,
// and full rises; nothing is dropped.
// Reset clears configuration to its defaults, all cell means, sums, scan
// min/max, the mask and both queues. History entries are valid-bit tracked, so
// no clearing pass is needed and the block accepts beats right after reset.
module cell_voltage_balance_decider import cvb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input queue side
    input  logic                 push,
    output logic                 full,
    input  logic                 i_command,
    input  logic [CELL_W-1:0]    i_cell_index,
    input  logic [RAW_W-1:0]     i_raw_adc,
    input  logic [SLOT_W-1:0]    i_history_slot,
    input  logic [MV_W-1:0]      i_min_reference_mv,
    // result queue side
    output logic                 empty,
    input  logic                 pop,
    output logic [MV_W-1:0]      o_average_mv,
    output logic                 o_average_changed,
    output logic [MV_W-1:0]      o_scan_min_mv,
    output logic [CELL_W-1:0]    o_scan_min_cell,
    output logic [MV_W-1:0]      o_scan_max_mv,
    output logic [CELL_W-1:0]    o_scan_max_cell,
    output logic [MASK_W-1:0]    o_balance_mask,
    output logic [CNT_W-1:0]     o_balance_count,
    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MV_W-1:0]      i_cfg_data
);

    logic             cq_push;
    logic             cq_full;
    logic             cq_pop;
    logic             cq_empty;
    t_cmd             front_cmd;
    t_cmd             head_cmd;
    logic             rq_push;
    logic [RQ_CW-1:0] rq_count;
    t_res             back_res;
    t_res             head_res;
    t_cfg_wr          cfg_wr;
    logic             res_pop;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    cvb_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_command          (i_command),
        .i_cell_index       (i_cell_index),
        .i_raw_adc          (i_raw_adc),
        .i_history_slot     (i_history_slot),
        .i_min_reference_mv (i_min_reference_mv),
        .o_cq_push          (cq_push),
        .o_cmd              (front_cmd),
        .i_cq_full          (cq_full)
    );

    cvb_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_cmd   (front_cmd),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_empty (cq_empty),
        .o_cmd   (head_cmd)
    );

    cvb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_wr),
        .i_cq_empty (cq_empty),
        .i_cmd      (head_cmd),
        .o_cq_pop   (cq_pop),
        .i_rq_count (rq_count),
        .o_rq_push  (rq_push),
        .o_res      (back_res)
    );

    assign res_pop = pop && !empty;

    cvb_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_res   (back_res),
        .i_pop   (res_pop),
        .o_empty (empty),
        .o_count (rq_count),
        .o_res   (head_res)
    );

    assign o_average_mv      = head_res.average_mv;
    assign o_average_changed = head_res.average_changed;
    assign o_scan_min_mv     = head_res.scan_min_mv;
    assign o_scan_min_cell   = head_res.scan_min_cell;
    assign o_scan_max_mv     = head_res.scan_max_mv;
    assign o_scan_max_cell   = head_res.scan_max_cell;
    assign o_balance_mask    = head_res.balance_mask;
    assign o_balance_count   = head_res.balance_count;

    // result queue credit scheme never overruns
    a_rq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rq_count <= RQ_CW'(RQ_DEPTH))
        else $error("result queue overflow");

    // count travels with the mask through the whole pipe
    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_balance_count == CNT_W'($countones(o_balance_mask))))
        else $error("balance count does not match mask");

    // scan minimum can never pass the scan maximum
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_scan_min_mv <= o_scan_max_mv))
        else $error("scan min above scan max");

    // no switch bit for a cell that does not exist
    a_mask_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_balance_mask >> CELLS) == '0))
        else $error("balance mask bit beyond last cell");

endmodule
